### rtl/i2cmws_pkg.sv
// ----------------------------------------------------------------------------
// i2cmws_pkg: shared types for the I2C master write sequencer
// Command codes, the input and result words, the classified queue entry and
// the queue status group passed between the front end and the engine.
// ----------------------------------------------------------------------------
package i2cmws_pkg;

  // Command codes as they arrive on the input word.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // Quarter periods per segment.
  localparam logic [2:0] Q_ONE  = 3'd1;
  localparam logic [2:0] Q_TWO  = 3'd2;
  localparam logic [2:0] Q_FOUR = 3'd4;

  // Bits shifted per byte, address plus R/W included.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_BYTE,
    KIND_STOP
  } kind_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       sda_level;
  } in_word_t;

  typedef struct packed {
    logic scl_out;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic nack_seen;
    logic done_res;
    logic rejected;
  } out_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       pin;
  } q_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/i2cmws_front.sv
// ----------------------------------------------------------------------------
// i2cmws_front: input acceptance and command classification
// Takes words from the input channel, decodes the command code into a word
// kind and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module i2cmws_front
  import i2cmws_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  q_stat_t  q_stat,
  output logic     push,
  output q_word_t  push_word
);

  kind_t kind;

  always_comb begin
    unique case (in_word.cmd)
      CMD_TICK:  kind = KIND_TICK;
      CMD_START: kind = KIND_START;
      CMD_BYTE:  kind = KIND_BYTE;
      CMD_STOP:  kind = KIND_STOP;
      default:   kind = KIND_TICK;
    endcase
  end

  // Only the low seven bits of a start word matter; the engine takes them.
  assign in_stall       = q_stat.full;
  assign push           = in_valid && !q_stat.full;
  assign push_word.kind = kind;
  assign push_word.data = in_word.data;
  assign push_word.pin  = in_word.sda_level;

endmodule

### rtl/i2cmws_queue.sv
// ----------------------------------------------------------------------------
// i2cmws_queue: short queue between front end and engine
// A small register FIFO so that the input side and the result side can each
// stall without holding up the other.
// ----------------------------------------------------------------------------
module i2cmws_queue
  import i2cmws_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_word_t push_word,
  input  logic    pop,
  output q_word_t pop_word,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_word_t            entry [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_word     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/i2cmws_engine.sv
// ----------------------------------------------------------------------------
// i2cmws_engine: bus sequencing engine and result register
// Feeds one queued word per cycle, unless the output stalls, to the bus state
// machine, holding the resulting line levels and flags in the output register.
// ----------------------------------------------------------------------------
module i2cmws_engine
  import i2cmws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] quarter_ticks,
  input  q_stat_t     q_stat,
  input  q_word_t     q_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
    PH_B_SET, PH_B_HIGH, PH_B_LOW,
    PH_A_SET, PH_A_HIGH, PH_A_LOW, PH_GAP,
    PH_SP_A, PH_SP_B, PH_SP_C
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [2:0]  q_left, q_left_next;
  logic [3:0]  bit_left, bit_left_next;
  logic [7:0]  shift_word, shift_word_next;
  logic        scl_level, scl_level_next;
  logic        sda_level_reg, sda_level_reg_next;
  logic        drive_on, drive_on_next;
  logic        nack_flag, nack_flag_next;
  logic        addr_mode, addr_mode_next;

  logic [15:0] limit;
  logic [16:0] tick_inc;
  logic [2:0]  q_dec;
  logic [3:0]  bits_dec;
  logic        done, rej;

  assign pop      = !q_stat.empty && (!out_valid || !out_stall);
  assign limit    = (quarter_ticks == '0) ? 16'd1 : quarter_ticks;
  assign tick_inc = {1'b0, tick_count} + 17'd1;
  assign q_dec    = (q_left != '0) ? q_left - 1'b1 : '0;
  assign bits_dec = (bit_left != '0) ? bit_left - 1'b1 : '0;

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    q_left_next        = q_left;
    bit_left_next      = bit_left;
    shift_word_next    = shift_word;
    scl_level_next     = scl_level;
    sda_level_reg_next = sda_level_reg;
    drive_on_next      = drive_on;
    nack_flag_next     = nack_flag;
    addr_mode_next     = addr_mode;
    done               = 1'b0;
    rej                = 1'b0;

    if (q_word.kind != KIND_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        drive_on_next   = 1'b1;
        tick_count_next = '0;
        case (q_word.kind)
          KIND_START: begin
            sda_level_reg_next = 1'b1;
            scl_level_next     = 1'b1;
            addr_mode_next     = 1'b1;
            bit_left_next      = BITS_PER_BYTE;
            shift_word_next    = {q_word.data[6:0], 1'b0};
            phase_next         = PH_ST_A;
            q_left_next        = Q_FOUR;
          end
          KIND_BYTE: begin
            addr_mode_next     = 1'b0;
            sda_level_reg_next = q_word.data[7];
            shift_word_next    = {q_word.data[6:0], 1'b0};
            bit_left_next      = BITS_PER_BYTE - 4'd1;
            phase_next         = PH_B_SET;
            q_left_next        = Q_ONE;
          end
          default: begin
            sda_level_reg_next = 1'b0;
            scl_level_next     = 1'b0;
            phase_next         = PH_SP_A;
            q_left_next        = Q_FOUR;
          end
        endcase
      end
    end else if (phase != PH_IDLE) begin
      if (tick_inc >= {1'b0, limit}) begin
        tick_count_next = '0;
        q_left_next     = q_dec;
        if (q_dec == '0) begin
          unique case (phase)
            PH_ST_A: begin
              sda_level_reg_next = 1'b0;
              phase_next = PH_ST_B;
              q_left_next = Q_TWO;
            end
            PH_ST_B: begin
              scl_level_next = 1'b0;
              phase_next = PH_ST_C;
              q_left_next = Q_FOUR;
            end
            PH_B_SET, PH_A_SET: begin
              scl_level_next = 1'b1;
              phase_next = (phase == PH_B_SET) ? PH_B_HIGH : PH_A_HIGH;
              q_left_next = Q_ONE;
            end
            PH_B_HIGH: begin
              scl_level_next = 1'b0;
              sda_level_reg_next = 1'b0;
              phase_next = PH_B_LOW;
              q_left_next = Q_TWO;
            end
            PH_ST_C, PH_B_LOW: begin
              if (phase == PH_ST_C || bit_left != '0) begin
                // Shift out the next data bit, MSB first.
                sda_level_reg_next = shift_word[7];
                shift_word_next    = {shift_word[6:0], 1'b0};
                bit_left_next      = bits_dec;
                phase_next         = PH_B_SET;
                q_left_next        = Q_ONE;
              end else begin
                // Release SDA for the acknowledge bit.
                drive_on_next      = 1'b0;
                sda_level_reg_next = 1'b0;
                phase_next         = PH_A_SET;
                q_left_next        = Q_ONE;
              end
            end
            PH_A_HIGH: begin
              nack_flag_next = q_word.pin;
              drive_on_next  = 1'b1;
              scl_level_next = 1'b0;
              phase_next = PH_A_LOW;
              q_left_next = Q_TWO;
            end
            PH_A_LOW: begin
              if (addr_mode) begin
                phase_next  = PH_GAP;
                q_left_next = Q_FOUR;
              end else begin
                phase_next = PH_IDLE;
                done = 1'b1;
              end
            end
            PH_SP_A: begin
              scl_level_next = 1'b1;
              phase_next = PH_SP_B;
              q_left_next = Q_TWO;
            end
            PH_SP_B: begin
              sda_level_reg_next = 1'b1;
              phase_next = PH_SP_C;
              q_left_next = Q_FOUR;
            end
            default: begin
              phase_next = PH_IDLE;
              done = 1'b1;
            end
          endcase
        end
      end else begin
        tick_count_next = tick_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      q_left        <= '0;
      bit_left      <= '0;
      shift_word    <= '0;
      scl_level     <= 1'b1;
      sda_level_reg <= 1'b1;
      drive_on      <= 1'b0;
      nack_flag     <= 1'b0;
      addr_mode     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        q_left        <= q_left_next;
        bit_left      <= bit_left_next;
        shift_word    <= shift_word_next;
        scl_level     <= scl_level_next;
        sda_level_reg <= sda_level_reg_next;
        drive_on      <= drive_on_next;
        nack_flag     <= nack_flag_next;
        addr_mode     <= addr_mode_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word.scl_out   <= scl_level_next;
      out_word.sda_out   <= sda_level_reg_next;
      out_word.sda_drive <= drive_on_next;
      out_word.busy_res  <= (phase_next != PH_IDLE);
      out_word.nack_seen <= nack_flag_next;
      out_word.done_res  <= done;
      out_word.rejected  <= rej;
    end
  end

endmodule

### rtl/i2c_master_write_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer: write-only I2C master bit engine
// Top level: configuration register, command front end, queue and engine.
// ----------------------------------------------------------------------------
// Each input word is either a tick or a command (start with a 7-bit address,
// send byte, stop), and each one produces exactly one result word carrying the
// SCL and SDA levels to drive, the SDA drive enable, busy, the last ack level,
// a done pulse and a rejected flag. Commands are taken only while the engine
// is idle; a command that arrives while busy is answered with rejected set and
// changes nothing. Bus timing is counted in quarter periods of quarter_ticks
// ticks each (zero behaves as one). The block takes one word per clock while
// the queue is not full, and the engine applies one queued word per cycle
// unless the output stalls: an accepted word is written into the queue, waits
// at its head until the engine takes it, and is then loaded into the engine's
// result register. The queue of QUEUE_DEPTH words lets the input
// keep flowing while a result waits on a stalled output. During the
// acknowledge bit SDA is released and the pin level sampled at the end of the
// SCL high quarter is reported as nack_seen. The configuration register should
// be written only while the block is idle.
module i2c_master_write_sequencer
  import i2cmws_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic [15:0] quarter_ticks;
  q_stat_t     q_stat;
  logic        push;
  q_word_t     push_word;
  logic        pop;
  q_word_t     pop_word;

  // Ticks per quarter period, reset to 25.
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_ticks <= 16'd25;
    end else if (cfg_write) begin
      quarter_ticks <= cfg_data;
    end
  end

  // The front end classifies commands and pushes every word into the queue.
  i2cmws_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  i2cmws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  // The engine owns the bus state and the result register.
  i2cmws_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .quarter_ticks (quarter_ticks),
    .q_stat        (q_stat),
    .q_word        (pop_word),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

`ifndef SYNTHESIS
  // A finished sequence always leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.done_res) |-> !out_word.busy_res)
    else $error("done_res with busy_res set");

  // A command is only rejected while a sequence is running.
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.rejected) |-> (out_word.busy_res && !out_word.done_res))
    else $error("rejected word without busy engine");

  // The input side stalls only when the queue is full, never when it is empty.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (q_stat.full && !q_stat.empty))
    else $error("input stalled with queue not full");
`endif

endmodule

### bench/tb_i2c_master_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_write_sequencer: self-checking bench for the I2C write engine
// Drives tick and command words through the valid/stall input, models the bus
// sequencing word by word, and checks every result word field by field while
// both sides idle and stall at random across several quarter_ticks settings.
// ----------------------------------------------------------------------------
module tb_i2c_master_write_sequencer;
  import i2cmws_pkg::*;

  // Cycles with no word moving on either side before the run is called hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the long receiver hold-off that fills the block's queue.
  localparam int HOLD_CYCLES = 60;

  // Bus segments the engine steps through, one per group of quarter periods.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START_HIGH,
    S_START_FALL,
    S_START_LOW,
    S_BIT_SETUP,
    S_BIT_HIGH,
    S_BIT_LOW,
    S_ACK_SETUP,
    S_ACK_HIGH,
    S_ACK_LOW,
    S_ADDR_GAP,
    S_STOP_LOW,
    S_STOP_RISE,
    S_STOP_HIGH
  } bus_seg_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_BEAT
  } rx_mode_t;

  // One directed row: the word to send and, where it is obvious, the result.
  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t lv;
  } drow_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;

  i2c_master_write_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bus model. This is the engine's state as the bench believes it to be; it
  // is stepped once per accepted word, in acceptance order.
  // --------------------------------------------------------------------------
  logic [15:0] quarter_ticks;
  bus_seg_t    seg_now;
  logic [15:0] tick_count;
  logic [2:0]  quarters_left;
  logic [3:0]  bits_left;
  logic [7:0]  shift_byte;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        drive_lvl;
  logic        nack_lvl;
  logic        addr_phase;

  function automatic void open_segment(bus_seg_t nxt, logic [2:0] quarters);
    seg_now = nxt;
    quarters_left = quarters;
    tick_count = '0;
  endfunction

  // Put the next data bit on SDA, MSB first, and begin its setup quarter.
  function automatic void load_next_bit();
    sda_lvl = shift_byte[7];
    shift_byte = {shift_byte[6:0], 1'b0};
    if (bits_left != 0) bits_left--;
    open_segment(S_BIT_SETUP, Q_ONE);
  endfunction

  // Apply one word to the model and return the line levels and flags that the
  // block should report for it.
  function automatic out_word_t line_levels_after(in_word_t w);
    out_word_t   lv;
    logic [16:0] limit;
    logic [16:0] count;
    logic        finished;
    lv = '0;
    finished = 1'b0;
    if (w.cmd != CMD_TICK) begin
      // Commands take effect at once and do not consume time.
      if (seg_now != S_IDLE) begin
        lv.rejected = 1'b1;
      end else if (w.cmd == CMD_START) begin
        drive_lvl = 1'b1;
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
        addr_phase = 1'b1;
        bits_left = BITS_PER_BYTE;
        // Seven address bits followed by a zero R/W bit.
        shift_byte = {w.data[6:0], 1'b0};
        open_segment(S_START_HIGH, Q_FOUR);
      end else if (w.cmd == CMD_BYTE) begin
        drive_lvl = 1'b1;
        addr_phase = 1'b0;
        bits_left = BITS_PER_BYTE;
        shift_byte = w.data;
        load_next_bit();
      end else begin
        drive_lvl = 1'b1;
        sda_lvl = 1'b0;
        scl_lvl = 1'b0;
        open_segment(S_STOP_LOW, Q_FOUR);
      end
    end else if (seg_now != S_IDLE) begin
      // A zero setting counts as one tick per quarter. Comparing with >= also
      // ends a quarter at once when the setting is lowered part way through.
      limit = (quarter_ticks == 16'd0) ? 17'd1 : {1'b0, quarter_ticks};
      count = {1'b0, tick_count} + 17'd1;
      if (count >= limit) begin
        tick_count = '0;
        if (quarters_left != 0) quarters_left--;
        if (quarters_left == 0) begin
          case (seg_now)
            S_START_HIGH: begin
              sda_lvl = 1'b0;
              open_segment(S_START_FALL, Q_TWO);
            end
            S_START_FALL: begin
              scl_lvl = 1'b0;
              open_segment(S_START_LOW, Q_FOUR);
            end
            S_START_LOW: load_next_bit();
            S_BIT_SETUP: begin
              scl_lvl = 1'b1;
              open_segment(S_BIT_HIGH, Q_ONE);
            end
            S_BIT_HIGH: begin
              scl_lvl = 1'b0;
              sda_lvl = 1'b0;
              open_segment(S_BIT_LOW, Q_TWO);
            end
            S_BIT_LOW: begin
              if (bits_left != 0) begin
                load_next_bit();
              end else begin
                // Release SDA for the acknowledge; the latch reads low.
                drive_lvl = 1'b0;
                sda_lvl = 1'b0;
                open_segment(S_ACK_SETUP, Q_ONE);
              end
            end
            S_ACK_SETUP: begin
              scl_lvl = 1'b1;
              open_segment(S_ACK_HIGH, Q_ONE);
            end
            S_ACK_HIGH: begin
              // The only tick on which the sampled pin level matters.
              nack_lvl = w.sda_level;
              drive_lvl = 1'b1;
              scl_lvl = 1'b0;
              open_segment(S_ACK_LOW, Q_TWO);
            end
            S_ACK_LOW: begin
              if (addr_phase) open_segment(S_ADDR_GAP, Q_FOUR);
              else finished = 1'b1;
            end
            S_STOP_LOW: begin
              scl_lvl = 1'b1;
              open_segment(S_STOP_RISE, Q_TWO);
            end
            S_STOP_RISE: begin
              sda_lvl = 1'b1;
              open_segment(S_STOP_HIGH, Q_FOUR);
            end
            default: finished = 1'b1;
          endcase
          if (finished) begin
            open_segment(S_IDLE, 3'd0);
            lv.done_res = 1'b1;
          end
        end
      end else begin
        tick_count = count[15:0];
      end
    end
    lv.scl_out = scl_lvl;
    lv.sda_out = sda_lvl;
    lv.sda_drive = drive_lvl;
    lv.busy_res = (seg_now != S_IDLE);
    lv.nack_seen = nack_lvl;
    return lv;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Every accepted word yields exactly one result word, so each
  // acceptance pushes one entry and each delivered result pops one.
  // --------------------------------------------------------------------------
  out_word_t pending_levels [$];
  int        errors = 0;
  logic      use_typed = 1'b0;
  out_word_t typed_word = '0;
  string     field_name [0:6] = '{"rejected", "done_res", "nack_seen", "busy_res",
                                  "sda_drive", "sda_out", "scl_out"};

  // Input side: step the model on each accepted word. Directed rows with a
  // hand-written result use that instead of the model's answer.
  always @(posedge clk) begin
    out_word_t lv;
    if (!rst && in_valid && !in_stall) begin
      lv = line_levels_after(in_word);
      pending_levels.push_back(use_typed ? typed_word : lv);
    end
  end

  // Output side: compare each delivered word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: result word %b arrived with nothing expected", $time, out_word);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        for (int i = 6; i >= 0; i--) begin
          if (out_word[i] !== want[i]) begin
            $display("%0t: %s mismatch, expected %b, got %b",
                     $time, field_name[i], want[i], out_word[i]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a run that stops moving words is a failure.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("i2c_master_write_sequencer regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It switches among stall patterns at random, and on request from
  // the sender holds off entirely (see HOLD_CYCLES) so the queue backs up.
  // --------------------------------------------------------------------------
  int       hold_asked = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t stall_mode = RX_FREE;
  int       rx_cycle = 0;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_cycle[1];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Words go out in bursts of random length separated by random gaps;
  // an occasional long burst gives stretches with no idling at all.
  // --------------------------------------------------------------------------
  int   burst_left = 0;
  logic in_txn = 1'b0;
  int   bytes_left = 0;

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering words and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  // Write the quarter period register with the pipeline empty. The engine
  // itself may still be mid-sequence, which is how a lowered setting gets
  // exercised part way through a quarter.
  task automatic write_quarter(input logic [15:0] v);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    quarter_ticks = v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic drow_t row(logic [1:0] cmd, logic [7:0] data, logic pin,
                                logic typed, out_word_t lv);
    drow_t r;
    r.w.cmd = cmd;
    r.w.data = data;
    r.w.sda_level = pin;
    r.typed = typed;
    r.lv = lv;
    return r;
  endfunction

  // Pick the next random word from the model's current state. Mostly this is
  // a well-formed transfer (start, zero to three bytes, stop) padded with
  // ticks, with some commands thrown at a busy engine and some stray commands
  // while idle, including byte or stop with no start before them.
  function automatic in_word_t next_word();
    in_word_t w;
    w.data = 8'($urandom_range(0, 255));
    w.sda_level = 1'($urandom_range(0, 1));
    w.cmd = CMD_TICK;
    if (seg_now != S_IDLE) begin
      if ($urandom_range(0, 19) == 0) w.cmd = 2'($urandom_range(1, 3));
    end else if ($urandom_range(0, 9) == 0) begin
      w.cmd = 2'($urandom_range(0, 3));
    end else if (!in_txn) begin
      w.cmd = CMD_START;
      in_txn = 1'b1;
      bytes_left = $urandom_range(0, 3);
    end else if (bytes_left != 0) begin
      w.cmd = CMD_BYTE;
      bytes_left--;
    end else begin
      w.cmd = CMD_STOP;
      in_txn = 1'b0;
    end
    return w;
  endfunction

  // Quarter period settings for the random part and the words sent under each.
  // Zero acts as one; the largest value is followed by a drop to one while a
  // quarter is under way.
  int phase_quarter [0:5] = '{0, 1, 2, 3, 65535, 1};
  int phase_items   [0:5] = '{200, 300, 250, 150, 30, 90};

  initial begin
    drow_t directed_rows [$];

    // Model state after reset.
    quarter_ticks = 16'd25;
    seg_now = S_IDLE;
    tick_count = '0;
    quarters_left = '0;
    bits_left = '0;
    shift_byte = '0;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    drive_lvl = 1'b0;
    nack_lvl = 1'b0;
    addr_phase = 1'b0;

    // Result fields in order: scl, sda, drive, busy, nack, done, rejected.
    // Ticks while idle change nothing and leave the lines released.
    directed_rows.push_back(row(CMD_TICK, 8'h00, 1'b0, 1'b1, 7'b1100000));
    directed_rows.push_back(row(CMD_TICK, 8'hFF, 1'b1, 1'b1, 7'b1100000));
    // Start with the top bit of data set; only the low seven are the address.
    directed_rows.push_back(row(CMD_START, 8'hFF, 1'b1, 1'b1, 7'b1111000));
    // Every command is refused while the start is in progress.
    directed_rows.push_back(row(CMD_START, 8'h00, 1'b0, 1'b1, 7'b1111001));
    directed_rows.push_back(row(CMD_BYTE, 8'hA5, 1'b1, 1'b1, 7'b1111001));
    directed_rows.push_back(row(CMD_STOP, 8'h5A, 1'b0, 1'b1, 7'b1111001));
    directed_rows.push_back(row(CMD_TICK, 8'h3C, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(CMD_TICK, 8'hC3, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(CMD_TICK, 8'hFF, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(CMD_TICK, 8'h00, 1'b0, 1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      use_typed = directed_rows[k].typed;
      typed_word = directed_rows[k].lv;
      send_word(directed_rows[k].w);
    end
    use_typed = 1'b0;

    for (int p = 0; p <= 5; p++) begin
      write_quarter(16'(phase_quarter[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        // Once, let the receiver hold off while words keep coming; once,
        // let the sender wait for every result before going on.
        if (p == 1 && n == 100) hold_asked++;
        if (p == 2 && n == 120) drain_results();
        send_word(next_word());
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("i2c_master_write_sequencer regression: pass");
    else $display("i2c_master_write_sequencer regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/i2cmws_pkg.sv
rtl/i2cmws_front.sv
rtl/i2cmws_queue.sv
rtl/i2cmws_engine.sv
rtl/i2c_master_write_sequencer.sv
bench/tb_i2c_master_write_sequencer.sv
